// ----- hw/rtl/homogeneous_point_transform_unit_defines.svh -----
// Assertion macros used by the transform unit top module.
// No dependencies; include with the bare file name.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HPT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define HPT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define HPT_ASSERT(label, clk, rst_n, prop)
`define HPT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- hw/rtl/hpt_pkg.sv -----
// Package for the homogeneous point transform unit: widths, codes, types.
// No dependencies.
package hpt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam int COORD_W     = 32;
  localparam int OUT_W       = 32;
  localparam int COORDS      = 3;
  localparam int LANES       = 4;
  localparam int MTX_N       = 16;

  localparam int PROD_W = ENTRY_WIDTH + COORD_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int NUM_W  = ACC_W + FRAC_BITS;
  localparam int DEN_W  = ACC_W;
  localparam int QB     = OUT_W;
  localparam int REM_W  = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
  localparam int WIDE_W = ENTRY_WIDTH + 32;

  localparam int DIV_LAT = QB + 2;
  localparam int LAT     = DIV_LAT + 3;

  localparam logic [ENTRY_WIDTH-1:0] ENTRY_MAX = {1'b0, {(ENTRY_WIDTH-1){1'b1}}};
  localparam logic [ENTRY_WIDTH-1:0] ENTRY_ONE =
    (FRAC_BITS < ENTRY_WIDTH - 1) ? (ENTRY_WIDTH'(1) << FRAC_BITS) : ENTRY_MAX;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_NORMAL = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             frc;
  } hpt_div_in_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QB-1:0]    quo;
    logic             neg;
    logic             ovf;
  } hpt_div_st_t;

  function automatic logic signed [ENTRY_WIDTH-1:0] clamp_entry(
    input logic signed [31:0] v);
    logic signed [WIDE_W-1:0] wv;
    logic signed [WIDE_W-1:0] mx;
    logic signed [WIDE_W-1:0] mn;
    wv = WIDE_W'(v);
    mx = (WIDE_W'(1) <<< (ENTRY_WIDTH - 1)) - WIDE_W'(1);
    mn = -mx - WIDE_W'(1);
    if (wv > mx) return mx[ENTRY_WIDTH-1:0];
    if (wv < mn) return mn[ENTRY_WIDTH-1:0];
    return wv[ENTRY_WIDTH-1:0];
  endfunction

endpackage

// ----- hw/rtl/hpt_if.sv -----
// Valid/ready channel interfaces for the transform unit.
// Depends on hpt_pkg.
interface hpt_in_if import hpt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [3:0]                entry_index;
  logic signed [31:0]        entry_value;
  logic signed [COORD_W-1:0] x_in;
  logic signed [COORD_W-1:0] y_in;
  logic signed [COORD_W-1:0] z_in;

  modport source (output valid, mode, entry_index, entry_value, x_in, y_in, z_in,
                  input ready);
  modport sink   (input valid, mode, entry_index, entry_value, x_in, y_in, z_in,
                  output ready);
endinterface

interface hpt_out_if import hpt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_out;
  logic signed [OUT_W-1:0] y_out;
  logic signed [OUT_W-1:0] z_out;
  logic                    w_zero;
  logic                    was_normal;

  modport source (output valid, x_out, y_out, z_out, w_zero, was_normal, input ready);
  modport sink   (input valid, x_out, y_out, z_out, w_zero, was_normal, output ready);
endinterface

// ----- hw/rtl/homogeneous_point_transform_unit.sv -----
// Homogeneous 4x4 point transform with perspective divide.
// Path: lane product and sum registers, merge register, divider input/bit/result registers.
// Throughput: one item per cycle when not stalled; the 32-stage bit-per-cycle divider sets depth.
// The whole pipeline holds while a finished result waits; write items leave bubbles.
// Reset (rst_n low, synchronous): matrix to identity, pipeline emptied, no beats taken.
module homogeneous_point_transform_unit import hpt_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  hpt_in_if.sink   in_ch,
  hpt_out_if.source out_ch
);

`include "homogeneous_point_transform_unit_defines.svh"

  logic signed [ENTRY_WIDTH-1:0] mtx_r [MTX_N];
  logic signed [ENTRY_WIDTH-1:0] coef [LANES][COORDS];
  logic signed [ENTRY_WIDTH-1:0] off [LANES];
  logic signed [COORD_W-1:0]     vin [COORDS];
  logic signed [ACC_W-1:0]       acc [LANES];
  hpt_div_in_t                   dv [COORDS];
  logic signed [OUT_W-1:0]       res [COORDS];
  logic                          merge_wz;
  logic                          en;
  logic                          in_acc;
  logic                          item;
  logic                          normal;
  logic [LAT-1:0]                vld_r;
  logic [LAT-1:0]                nrm_r;
  logic [DIV_LAT-1:0]            wz_r;

  assign en           = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready  = en && rst_n;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign normal       = (in_ch.mode == MODE_NORMAL);
  assign item         = in_acc && ((in_ch.mode == MODE_POINT) || normal);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MTX_N; i++) mtx_r[i] <= (i % 5 == 0) ? ENTRY_ONE : '0;
    end else if (in_acc && in_ch.mode == MODE_WRITE) begin
      mtx_r[in_ch.entry_index] <= clamp_entry(in_ch.entry_value);
    end
  end

  // point: column c of rows 0..2 plus row 3; normal: row c of the upper 3x3
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      for (int k = 0; k < COORDS; k++) begin
        if (normal && c < COORDS) coef[c][k] = mtx_r[c*4 + k];
        else                      coef[c][k] = mtx_r[k*4 + c];
      end
      off[c] = mtx_r[12 + c];
    end
  end

  assign vin[0] = in_ch.x_in;
  assign vin[1] = in_ch.y_in;
  assign vin[2] = in_ch.z_in;

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    hpt_lane u_lane (
      .clk    (clk),
      .en     (en),
      .coef   (coef[c]),
      .off    (off[c]),
      .off_en (!normal),
      .v      (vin),
      .acc_r  (acc[c])
    );
  end

  hpt_merge u_merge (
    .clk    (clk),
    .en     (en),
    .acc    (acc),
    .normal (nrm_r[1]),
    .dv_r   (dv),
    .wz_r   (merge_wz)
  );

  for (genvar c = 0; c < COORDS; c++) begin : g_div
    hpt_div u_div (
      .clk   (clk),
      .en    (en),
      .din   (dv[c]),
      .res_r (res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], item};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_r <= {nrm_r[LAT-2:0], normal};
      wz_r  <= {wz_r[DIV_LAT-2:0], merge_wz};
    end
  end

  assign out_ch.valid      = vld_r[LAT-1];
  assign out_ch.x_out      = res[0];
  assign out_ch.y_out      = res[1];
  assign out_ch.z_out      = res[2];
  assign out_ch.w_zero     = wz_r[DIV_LAT-1];
  assign out_ch.was_normal = nrm_r[LAT-1];

  `HPT_ASSERT_ALWAYS(a_reset_identity, clk,
    !rst_n |=> (mtx_r[0] == ENTRY_ONE && mtx_r[1] == '0 && mtx_r[15] == ENTRY_ONE))
  `HPT_ASSERT(a_write_stored, clk, rst_n,
    (in_acc && in_ch.mode == MODE_WRITE) |=>
      (mtx_r[$past(in_ch.entry_index)] == $past(clamp_entry(in_ch.entry_value))))
  `HPT_ASSERT(a_flags_exclusive, clk, rst_n,
    out_ch.valid |-> !(out_ch.w_zero && out_ch.was_normal))
  `HPT_ASSERT(a_wzero_bounds, clk, rst_n,
    (out_ch.valid && out_ch.w_zero) |->
      ((out_ch.x_out == OUT_MAX || out_ch.x_out == OUT_MIN || out_ch.x_out == '0) &&
       (out_ch.y_out == OUT_MAX || out_ch.y_out == OUT_MIN || out_ch.y_out == '0) &&
       (out_ch.z_out == OUT_MAX || out_ch.z_out == OUT_MIN || out_ch.z_out == '0)))

endmodule

// ----- hw/rtl/hpt_lane.sv -----
// One dot-product lane: three multiplies, then sum with optional offset.
// Depends on hpt_pkg.
module hpt_lane import hpt_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ENTRY_WIDTH-1:0] coef [COORDS],
  input  logic signed [ENTRY_WIDTH-1:0] off,
  input  logic                          off_en,
  input  logic signed [COORD_W-1:0]     v [COORDS],
  output logic signed [ACC_W-1:0]       acc_r
);

  logic signed [PROD_W-1:0] prod_r [COORDS];
  logic signed [ACC_W-1:0]  off_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < COORDS; k++) prod_r[k] <= coef[k] * v[k];
      off_r <= off_en ? (ACC_W'(off) <<< FRAC_BITS) : '0;
    end
  end

  always_comb begin
    acc_nxt = off_r;
    for (int k = 0; k < COORDS; k++) acc_nxt = acc_nxt + ACC_W'(prod_r[k]);
  end

  always_ff @(posedge clk) begin
    if (en) acc_r <= acc_nxt;
  end

endmodule

// ----- hw/rtl/hpt_merge.sv -----
// Merge stage: turns lane sums into numerator/denominator for each divider.
// Depends on hpt_pkg.
module hpt_merge import hpt_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ACC_W-1:0] acc [LANES],
  input  logic                    normal,
  output hpt_div_in_t             dv_r [COORDS],
  output logic                    wz_r
);

  hpt_div_in_t      dv_nxt [COORDS];
  logic             wz_nxt;
  logic [ACC_W-1:0] wmag;
  logic [ACC_W-1:0] mag;

  always_comb begin
    wz_nxt = !normal && (acc[LANES-1] == '0);
    wmag   = acc[LANES-1][ACC_W-1] ? ACC_W'(-acc[LANES-1]) : ACC_W'(acc[LANES-1]);
    mag    = '0;
    for (int c = 0; c < COORDS; c++) begin
      mag = acc[c][ACC_W-1] ? ACC_W'(-acc[c]) : ACC_W'(acc[c]);
      if (normal) begin
        // plain rounding shift, done as a divide by one
        dv_nxt[c].num = NUM_W'(mag);
        dv_nxt[c].den = DEN_W'(1) << FRAC_BITS;
        dv_nxt[c].neg = acc[c][ACC_W-1];
        dv_nxt[c].frc = 1'b0;
      end else begin
        dv_nxt[c].num = NUM_W'(mag) << FRAC_BITS;
        dv_nxt[c].den = wz_nxt ? DEN_W'(1) : wmag;
        dv_nxt[c].neg = acc[c][ACC_W-1] ^ acc[LANES-1][ACC_W-1];
        dv_nxt[c].frc = wz_nxt && (mag != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r <= dv_nxt;
      wz_r <= wz_nxt;
    end
  end

endmodule

// ----- hw/rtl/hpt_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, rounding and saturation.
// Depends on hpt_pkg.
module hpt_div import hpt_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  hpt_div_in_t             din,
  output logic signed [OUT_W-1:0] res_r
);

  localparam logic [QB:0] HALF = (QB + 1)'(1) << (QB - 1);

  hpt_div_st_t      st_r [QB+1];
  logic             rnd;
  logic [QB:0]      qr;
  logic [OUT_W-1:0] res_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].rem <= REM_W'(din.num);
      st_r[0].den <= din.den;
      st_r[0].quo <= '0;
      st_r[0].neg <= din.neg;
      // quotient would not fit in QB bits, or saturation is forced by frc
      st_r[0].ovf <= din.frc ||
                     ((REM_W + 1)'(din.num) >= ((REM_W + 1)'(din.den) << QB));
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int B = QB - 1 - i;
    logic [REM_W:0] diff;
    hpt_div_st_t    st_nxt;
    assign diff = {1'b0, st_r[i].rem} - ((REM_W + 1)'(st_r[i].den) << B);
    always_comb begin
      st_nxt = st_r[i];
      if (!diff[REM_W]) begin
        st_nxt.rem    = diff[REM_W-1:0];
        st_nxt.quo[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) st_r[i+1] <= st_nxt;
    end
  end

  always_comb begin
    rnd = (((REM_W + 1)'(st_r[QB].rem)) << 1) >= (REM_W + 1)'(st_r[QB].den);
    qr  = {1'b0, st_r[QB].quo} + (QB + 1)'(rnd);
    if (st_r[QB].neg) begin
      if (st_r[QB].ovf || qr > HALF) res_nxt = OUT_MIN;
      else                           res_nxt = OUT_W'(-qr);
    end else begin
      if (st_r[QB].ovf || qr >= HALF) res_nxt = OUT_MAX;
      else                            res_nxt = qr[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for homogeneous_point_transform_unit: a directed stimulus table,
// then random beats in all four modes. Each result is checked vs. a table or in-bench model.
// Depends on hpt_pkg, hpt_if.sv and the transform unit RTL.
module testbench import hpt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS = 630;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               wz;
    logic               nrm;
  } xform_res_t;

  typedef struct {
    mode_t              md;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 typed;
    xform_res_t         res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  hpt_in_if  in_ch();
  hpt_out_if out_ch();

  homogeneous_point_transform_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic signed [31:0] mtx[16];
  xform_res_t         pending_q[$];
  int                 mismatches;
  int                 cycle_cnt;
  bit                 hold_req;
  bit                 hold_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic logic [127:0] mag128(logic signed [127:0] v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic signed [31:0] sat_q(logic neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'h8000_0000) return OUT_MIN;
      return -32'(m);
    end
    if (m > 128'h7FFF_FFFF) return OUT_MAX;
    return 32'(m);
  endfunction

  function automatic logic [127:0] rnd_shift(logic [127:0] m);
    return (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  endfunction

  function automatic xform_res_t transform_item(mode_t md, logic signed [31:0] x,
                                                logic signed [31:0] y,
                                                logic signed [31:0] z);
    xform_res_t r;
    logic signed [127:0] v[3];
    logic signed [127:0] acc[4];
    logic signed [127:0] e;
    logic [127:0] wm;
    logic [127:0] n;
    logic [127:0] q;
    logic [127:0] rm;
    logic wneg;
    v[0] = x; v[1] = y; v[2] = z;
    r.wz = 1'b0;
    r.nrm = (md == MODE_NORMAL);
    if (md == MODE_NORMAL) begin
      // rows of the upper 3x3 against the column vector
      for (int c = 0; c < 3; c++) begin
        acc[c] = 0;
        for (int k = 0; k < 3; k++) begin
          e = mtx[c*4+k];
          acc[c] += e * v[k];
        end
      end
    end else begin
      for (int c = 0; c < 4; c++) begin
        e = mtx[12+c];
        acc[c] = e <<< FRAC_BITS;
        for (int k = 0; k < 3; k++) begin
          e = mtx[k*4+c];
          acc[c] += e * v[k];
        end
      end
    end
    if (md == MODE_NORMAL || acc[3] == (128'sd1 <<< (2*FRAC_BITS))) begin
      r.x = sat_q(acc[0] < 0, rnd_shift(mag128(acc[0])));
      r.y = sat_q(acc[1] < 0, rnd_shift(mag128(acc[1])));
      r.z = sat_q(acc[2] < 0, rnd_shift(mag128(acc[2])));
    end else if (acc[3] == 0) begin
      r.wz = 1'b1;
      r.x = acc[0] < 0 ? OUT_MIN : (acc[0] != 0 ? OUT_MAX : '0);
      r.y = acc[1] < 0 ? OUT_MIN : (acc[1] != 0 ? OUT_MAX : '0);
      r.z = acc[2] < 0 ? OUT_MIN : (acc[2] != 0 ? OUT_MAX : '0);
    end else begin
      wneg = acc[3] < 0;
      wm = mag128(acc[3]);
      for (int c = 0; c < 3; c++) begin
        n = mag128(acc[c]) << FRAC_BITS;
        q = n / wm;
        rm = n % wm;
        if ((rm << 1) >= wm) q = q + 1;
        case (c)
          0: r.x = sat_q((acc[c] < 0) != wneg, q);
          1: r.y = sat_q((acc[c] < 0) != wneg, q);
          default: r.z = sat_q((acc[c] < 0) != wneg, q);
        endcase
      end
    end
    return r;
  endfunction

  // ---------------- driving ----------------
  function automatic stim_row_t row(mode_t md, logic [3:0] idx, logic signed [31:0] val,
                                    logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, bit typed,
                                    logic signed [31:0] ex, logic signed [31:0] ey,
                                    logic signed [31:0] ez, logic ewz, logic enrm);
    stim_row_t s;
    s.md = md; s.idx = idx; s.val = val; s.x = x; s.y = y; s.z = z;
    s.typed = typed;
    s.res.x = ex; s.res.y = ey; s.res.z = ez; s.res.wz = ewz; s.res.nrm = enrm;
    return s;
  endfunction

  task automatic send_beat(stim_row_t s);
    xform_res_t r;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= s.md;
    in_ch.entry_index <= s.idx;
    in_ch.entry_value <= s.val;
    in_ch.x_in        <= s.x;
    in_ch.y_in        <= s.y;
    in_ch.z_in        <= s.z;
    do @(posedge clk); while (!in_ch.ready);
    case (s.md)
      MODE_WRITE: mtx[s.idx] = clamp_entry_tb(s.val);
      MODE_POINT, MODE_NORMAL: begin
        r = transform_item(s.md, s.x, s.y, s.z);
        pending_q.push_back(s.typed ? s.res : r);
      end
      default: ;
    endcase
  endtask

  // entries are as wide as the written value, so the clamp never bites here
  function automatic logic signed [31:0] clamp_entry_tb(logic signed [31:0] v);
    return v;
  endfunction

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      in_ch.mode  <= 2'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed(32'($urandom_range(16*65536))) - 32'sd524288;
      4: return Q_ONE * $signed(32'($urandom_range(8))) - 32'sd262144;
      5: return $urandom_range(1) ? OUT_MAX : OUT_MIN;
      6: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t rand_item();
    stim_row_t s;
    int p;
    s = row(MODE_POINT, 4'($urandom), $urandom, rand_coord(), rand_coord(),
            rand_coord(), 1'b0, 0, 0, 0, 1'b0, 1'b0);
    p = $urandom_range(99);
    if (p < 25) begin
      s.md = MODE_WRITE;
      case ($urandom_range(9))
        0, 1, 2: s.val = $signed(32'($urandom_range(8*65536))) - 32'sd262144;
        3, 4: s.val = 0;
        5, 6: s.val = Q_ONE;
        7: s.val = $urandom_range(1) ? OUT_MAX : OUT_MIN;
        default: s.val = $urandom;
      endcase
      // column 3 often rewritten so w == 1.0 and w == 0 cases keep recurring
      if ($urandom_range(2) == 0) s.idx = 4'(4 * $urandom_range(3) + 3);
    end else if (p < 67) s.md = MODE_POINT;
    else if (p < 95) s.md = MODE_NORMAL;
    else s.md = MODE_RSVD;
    return s;
  endfunction

  // ---------------- result side ----------------
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    xform_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result beat x=%h y=%h z=%h", out_ch.x_out,
                   out_ch.y_out, out_ch.z_out);
      end else begin
        e = pending_q.pop_front();
        if (out_ch.x_out !== e.x || out_ch.y_out !== e.y || out_ch.z_out !== e.z ||
            out_ch.w_zero !== e.wz || out_ch.was_normal !== e.nrm) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp %h %h %h wz=%b nrm=%b got %h %h %h wz=%b nrm=%b",
                     e.x, e.y, e.z, e.wz, e.nrm, out_ch.x_out, out_ch.y_out,
                     out_ch.z_out, out_ch.w_zero, out_ch.was_normal);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    stim_row_t tbl[$];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.x_in = '0;
    in_ch.y_in = '0;
    in_ch.z_in = '0;
    mismatches = 0;
    cycle_cnt = 0;
    hold_req = 1'b0;
    for (int i = 0; i < 16; i++) mtx[i] = (i % 5 == 0) ? Q_ONE : 32'sd0;

    // identity after reset, extremes, zero w, then predicted rows
    tbl.push_back(row(MODE_POINT, 0, 0, Q_ONE, 2*Q_ONE, -3*Q_ONE, 1,
                      Q_ONE, 2*Q_ONE, -3*Q_ONE, 1'b0, 1'b0));
    tbl.push_back(row(MODE_POINT, 0, 0, OUT_MAX, OUT_MIN, 0, 1,
                      OUT_MAX, OUT_MIN, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_NORMAL, 0, 0, OUT_MIN, OUT_MAX, 1, 1,
                      OUT_MIN, OUT_MAX, 1, 1'b0, 1'b1));
    tbl.push_back(row(MODE_RSVD, 4'hF, OUT_MIN, 7, 7, 7, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_WRITE, 15, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_POINT, 0, 0, 5, -5, 0, 1, OUT_MAX, OUT_MIN, 0, 1'b1, 1'b0));
    tbl.push_back(row(MODE_NORMAL, 0, 0, 5, -5, 0, 1, 5, -5, 0, 1'b0, 1'b1));
    tbl.push_back(row(MODE_WRITE, 15, 2*Q_ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_POINT, 0, 0, 4*Q_ONE, -3, 7*Q_ONE, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_WRITE, 0, OUT_MAX, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_WRITE, 5, OUT_MIN, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_POINT, 0, 0, OUT_MAX, OUT_MAX, OUT_MIN, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_NORMAL, 0, 0, OUT_MIN, OUT_MIN, OUT_MAX, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_WRITE, 3, -Q_ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_POINT, 0, 0, -3*Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_POINT, 0, 0, 2*Q_ONE, 12345, -99, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_WRITE, 7, 32'sh0000_8000, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_POINT, 0, 0, 3, -1, Q_ONE, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_WRITE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_WRITE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_WRITE, 15, Q_ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    tbl.push_back(row(MODE_POINT, 0, 0, 32'sh7FFF_8000, -32'sh0000_8000, 1, 0,
                      0, 0, 0, 1'b0, 1'b0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (tbl[i]) begin
      send_beat(tbl[i]);
      idle_gap(pick_gap());
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // receiver stops for a long stretch while beats keep coming
      if (i == RAND_ITEMS / 3) hold_req = 1'b1;
      if (i == 2 * RAND_ITEMS / 3) begin
        idle_gap(1);
        wait (pending_q.size() == 0);
      end
      send_beat(rand_item());
      if (hold_req && !hold_done) idle_gap(0);
      else idle_gap(pick_gap());
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/hpt_pkg.sv
hw/rtl/hpt_if.sv
hw/rtl/hpt_lane.sv
hw/rtl/hpt_merge.sv
hw/rtl/hpt_div.sv
hw/rtl/homogeneous_point_transform_unit.sv
dv/testbench.sv
